>>> rtl/core/assert_macros.svh
// Assertion macros shared by the edit distance core.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

>>> rtl/core/led_pkg.sv
// Shared types and constants of the edit distance core.
// No dependencies; imported by every module and interface of the core.
package led_pkg;

  // Longest string that is stored; longer input sets the overflow flag
  localparam int MAX_LEN     = 64;
  localparam int IDX_W       = $clog2(MAX_LEN);
  localparam int LEN_W       = $clog2(MAX_LEN + 1);
  localparam int DIST_W      = 7;
  localparam int KIND_W      = 2;
  localparam int SYM_W       = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input kind codes
  localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD_A,
    OP_STEP_B,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [SYM_W-1:0] sym;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } back_state_t;

endpackage

>>> rtl/core/led_if.sv
// Handshake channels of the edit distance core: input items and results.
// Depends on led_pkg for field widths.
interface led_in_if;
  logic                        valid;
  logic                        ready;
  logic [led_pkg::KIND_W-1:0]  kind;
  logic [led_pkg::SYM_W-1:0]   symbol;

  modport source (output valid, output kind, output symbol, input ready);
  modport sink   (input valid, input kind, input symbol, output ready);
endinterface

interface led_out_if;
  logic                        valid;
  logic                        ready;
  logic [led_pkg::DIST_W-1:0]  distance;
  logic                        overflow;

  modport source (output valid, output distance, output overflow, input ready);
  modport sink   (input valid, input distance, input overflow, output ready);
endinterface

>>> rtl/core/levenshtein_edit_distance_unit.sv
// Levenshtein edit distance unit, top level.
// Channels: in_chan carries items with kind (0 = first-string byte, 1 = second-string
// byte, 2 = finish) and symbol; kind 3 is accepted and dropped. out_chan carries one
// result per finish item: distance and overflow (either string longer than 64 bytes).
// Both channels use valid/ready; an item moves when both are high.
// A front end decodes items into a two-entry command queue; the back end runs them.
// Work per item in the back end: a first-string byte is stored directly; a second-string
// byte walks n entries, where n is the stored first-string length (up to 64), as it
// walks the DP row memory one entry a cycle through its single read port; a finish
// passes through the finish state, and its result is then registered in the output
// register.
// If the receiver stalls, the result holds in the output register; the unit keeps
// taking first- and second-string items, and the next finish waits for that
// register to empty. Input stalls only while the queue is full.
// Reset (rst_n low, synchronous) clears the pair state, the queue and the result
// register; the string and row memories need no clearing pass.
// Depends on led_pkg, led_if, led_front, led_cmd_queue and led_back.
module levenshtein_edit_distance_unit (
  input  logic       clk,
  input  logic       rst_n,
  led_in_if.sink     in_chan,
  led_out_if.source  out_chan
);
  import led_pkg::*;

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  // Accept and decode items
  led_front u_front (
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  // Decouple front from back
  led_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_cmd    (q_cmd),
    .pop_ready  (q_ready)
  );

  // Run commands against the stored string and DP row
  led_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_ready (q_ready),
    .out_chan  (out_chan)
  );

endmodule

>>> rtl/core/led_cmd_queue.sv
// Short command queue between the front and back of the edit distance core.
// Depends on led_pkg (cmd_t, QUEUE_DEPTH) and assert_macros.svh.
`include "assert_macros.svh"

module led_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  led_pkg::cmd_t  push_cmd,
  output logic           push_ready,
  output logic           pop_valid,
  output led_pkg::cmd_t  pop_cmd,
  input  logic           pop_ready
);
  import led_pkg::*;

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  // Handshake flags
  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  `ASSERT_AT(a_count_bound, clk, rst_n, count_r <= QCNT_W'(QUEUE_DEPTH))
  `ASSERT_AT(a_count_grows, clk, rst_n, (push && !pop) |=> (count_r == $past(count_r) + QCNT_W'(1)))

endmodule

>>> rtl/core/led_front.sv
// Front end of the edit distance core: accepts input items and decodes them.
// Depends on led_pkg (op_t, cmd_t) and led_if (led_in_if).
module led_front (
  led_in_if.sink         in_chan,
  output logic           push_valid,
  output led_pkg::cmd_t  push_cmd,
  input  logic           push_ready
);
  import led_pkg::*;

  logic known_kind;

  // Accept whenever the queue has room; drop the unused kind code
  assign in_chan.ready = push_ready;

  // Decode the kind field into a back-end operation
  always_comb begin
    known_kind   = 1'b1;
    push_cmd.op  = OP_LOAD_A;
    push_cmd.sym = in_chan.symbol;
    case (in_chan.kind)
      KIND_FIRST:  push_cmd.op = OP_LOAD_A;
      KIND_SECOND: push_cmd.op = OP_STEP_B;
      KIND_FINISH: push_cmd.op = OP_FINISH;
      default:     known_kind  = 1'b0;
    endcase
  end

  assign push_valid = in_chan.valid && known_kind;

endmodule

>>> rtl/core/led_back.sv
// Back end of the edit distance core: string store, DP row walk, result register.
// Depends on led_pkg, led_if (led_out_if) and assert_macros.svh.
`include "assert_macros.svh"

module led_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  led_pkg::cmd_t  cmd,
  output logic           cmd_ready,
  led_out_if.source      out_chan
);
  import led_pkg::*;

  // Storage: first-string bytes and DP row entries 1..MAX_LEN
  logic [SYM_W-1:0]  str_mem [MAX_LEN];
  logic [DIST_W-1:0] row_mem [MAX_LEN];

  back_state_t       state_r, state_nxt;
  logic [LEN_W-1:0]  fl_r, fl_nxt;
  logic [LEN_W-1:0]  sl_r, sl_nxt;
  logic              ovf_r, ovf_nxt;
  logic [DIST_W-1:0] row0_r, row0_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [DIST_W-1:0] diag_r, diag_nxt;
  logic [DIST_W-1:0] left_r, left_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic              fin_zero_r, fin_zero_nxt;
  logic              fin_ovf_r, fin_ovf_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] out_dist_r, out_dist_nxt;
  logic              out_ovf_r, out_ovf_nxt;
  logic [DIST_W-1:0] rd_row_r;
  logic [SYM_W-1:0]  rd_chr_r;

  logic              pop;
  logic              walk_last;
  logic              walk_start;
  logic [IDX_W-1:0]  rd_addr;
  logic              row_we, str_we;
  logic [IDX_W-1:0]  wr_addr;
  logic [DIST_W-1:0] row_wd;
  logic [DIST_W-1:0] cand_left, cand_up, cand_diag, min_lu, new_val;

  // Take a command only in idle; a finish also needs a free result register
  assign cmd_ready  = (state_r == ST_IDLE) && ((cmd.op != OP_FINISH) || !out_valid_r);
  assign pop        = cmd_valid && cmd_ready;
  assign walk_start = (cmd.op == OP_STEP_B) && (sl_r < LEN_W'(MAX_LEN)) && (fl_r != '0);
  assign walk_last  = ((LEN_W'(idx_r) + LEN_W'(1)) == fl_r);

  // One DP cell: match keeps the diagonal, else one plus the smallest neighbor
  assign cand_left = left_r + DIST_W'(1);
  assign cand_up   = rd_row_r + DIST_W'(1);
  assign cand_diag = diag_r + DIST_W'(1);
  assign min_lu    = (cand_left < cand_up) ? cand_left : cand_up;
  assign new_val   = (rd_chr_r == sym_r) ? diag_r :
                     ((min_lu < cand_diag) ? min_lu : cand_diag);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (pop && (cmd.op == OP_FINISH)) begin
          state_nxt = ST_FINISH;
        end else if (pop && walk_start) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory controls and result register
  always_comb begin
    fl_nxt        = fl_r;
    sl_nxt        = sl_r;
    ovf_nxt       = ovf_r;
    row0_nxt      = row0_r;
    idx_nxt       = idx_r;
    diag_nxt      = diag_r;
    left_nxt      = left_r;
    sym_nxt       = sym_r;
    fin_zero_nxt  = fin_zero_r;
    fin_ovf_nxt   = fin_ovf_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_dist_nxt  = out_dist_r;
    out_ovf_nxt   = out_ovf_r;
    rd_addr       = idx_r + IDX_W'(1);
    row_we        = 1'b0;
    str_we        = 1'b0;
    wr_addr       = idx_r;
    row_wd        = new_val;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          case (cmd.op)
            OP_LOAD_A: begin
              if (sl_r == '0) begin
                if (fl_r >= LEN_W'(MAX_LEN)) begin
                  ovf_nxt = 1'b1;
                end else begin
                  str_we  = 1'b1;
                  row_we  = 1'b1;
                  wr_addr = IDX_W'(fl_r);
                  row_wd  = DIST_W'(fl_r + LEN_W'(1));
                  fl_nxt  = fl_r + LEN_W'(1);
                end
              end
            end
            OP_STEP_B: begin
              if (sl_r >= LEN_W'(MAX_LEN)) begin
                ovf_nxt = 1'b1;
              end else begin
                sl_nxt   = sl_r + LEN_W'(1);
                diag_nxt = row0_r;
                row0_nxt = DIST_W'(sl_r + LEN_W'(1));
                left_nxt = DIST_W'(sl_r + LEN_W'(1));
                sym_nxt  = cmd.sym;
                idx_nxt  = '0;
                rd_addr  = '0;
              end
            end
            OP_FINISH: begin
              fin_zero_nxt = (fl_r == '0);
              fin_ovf_nxt  = ovf_r;
              diag_nxt     = row0_r;
              rd_addr      = IDX_W'(fl_r - LEN_W'(1));
              fl_nxt       = '0;
              sl_nxt       = '0;
              ovf_nxt      = 1'b0;
              row0_nxt     = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        row_we   = 1'b1;
        wr_addr  = idx_r;
        row_wd   = new_val;
        left_nxt = new_val;
        diag_nxt = rd_row_r;
        idx_nxt  = idx_r + IDX_W'(1);
      end
      ST_FINISH: begin
        out_valid_nxt = 1'b1;
        out_dist_nxt  = fin_zero_r ? diag_r : rd_row_r;
        out_ovf_nxt   = fin_ovf_r;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fl_r        <= '0;
      sl_r        <= '0;
      ovf_r       <= 1'b0;
      row0_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fl_r        <= fl_nxt;
      sl_r        <= sl_nxt;
      ovf_r       <= ovf_nxt;
      row0_r      <= row0_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    diag_r     <= diag_nxt;
    left_r     <= left_nxt;
    sym_r      <= sym_nxt;
    fin_zero_r <= fin_zero_nxt;
    fin_ovf_r  <= fin_ovf_nxt;
    out_dist_r <= out_dist_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  // Memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (str_we) begin
      str_mem[wr_addr] <= cmd.sym;
    end
    if (row_we) begin
      row_mem[wr_addr] <= row_wd;
    end
    rd_row_r <= row_mem[rd_addr];
    rd_chr_r <= str_mem[rd_addr];
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.distance = out_dist_r;
  assign out_chan.overflow = out_ovf_r;

  `ASSERT_AT(a_walk_in_row, clk, rst_n, (state_r == ST_WALK) |-> (LEN_W'(idx_r) < fl_r))
  `ASSERT_AT(a_len_bound, clk, rst_n, (fl_r <= LEN_W'(MAX_LEN)) && (sl_r <= LEN_W'(MAX_LEN)))
  `ASSERT_NEVER(a_no_clobber, clk, rst_n, (state_r == ST_FINISH) && out_valid_r)

endmodule
